[sv/iss_pkg.sv]
// iss_pkg: shared constants and types for the insertion sorter.
// Used by iss_cell, insertion_sort_top and the testbench; no dependencies.
`timescale 1ns / 1ps

package iss_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast value
    logic shift;  // drain: move every entry one cell toward cell 0
  } cell_ctl_t;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
  } cell_data_t;

endpackage

[sv/iss_cell.sv]
// iss_cell: one slot of the sorted chain; holds one entry and a valid bit.
// Depends on iss_pkg.
`timescale 1ns / 1ps

module iss_cell
  import iss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] ins_val,
  input  cell_data_t               prev_data,  // cell toward the low end
  input  logic                     prev_gt,
  input  cell_data_t               next_data,  // cell toward the high end
  output cell_data_t               data,
  output logic                     gt
);

  logic                     vld_r, vld_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;

  // An empty cell counts as +infinity, so new values settle before it.
  assign gt = !vld_r || (val_r > ins_val);

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (ctl.shift) begin
      vld_nxt = next_data.vld;
      val_nxt = next_data.val;
    end else if (ctl.ins && gt) begin
      if (!prev_gt) begin
        vld_nxt = 1'b1;
        val_nxt = ins_val;
      end else begin
        vld_nxt = prev_data.vld;
        val_nxt = prev_data.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign data.vld = vld_r;
  assign data.val = val_r;

endmodule

[sv/insertion_sort_top.sv]
// insertion_sort_top: streaming insertion sorter built from a chain of iss_cell.
// Depends on iss_pkg and iss_cell.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid in_stall in_value in_last          | sink
//   out     | out_valid out_stall out_sorted_value        | source
//           | out_end_of_set out_overflow                 |
//
// Each input beat's value is compared against all cells at once and the chain shifts
// up by one from the insertion point; if the chain is full, the value is dropped and
// the overflow flag set. A beat with in_last starts a drain of all entries held, one
// output beat per cycle while out_stall is low; the chain shifts down toward cell 0.
// in_stall is high for the whole drain. out_stall freezes the drain in place.
// Reset empties the chain and clears the overflow flag.
`timescale 1ns / 1ps

module insertion_sort_top
  import iss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_end_of_set,
  output logic                     out_overflow
);

  logic       drain_r, drain_nxt;
  logic       drop_r, drop_nxt;
  logic       in_acc, out_acc, full;
  cell_ctl_t  ctl;

  cell_data_t cdata [MAX_ITEMS];
  cell_data_t prev_d [MAX_ITEMS];
  cell_data_t next_d [MAX_ITEMS];
  logic       cgt   [MAX_ITEMS];
  logic       pgt   [MAX_ITEMS];

  assign in_stall  = drain_r;
  assign in_acc    = in_valid && !drain_r;
  assign out_valid = drain_r;
  assign out_acc   = drain_r && !out_stall;
  assign full      = cdata[MAX_ITEMS-1].vld;

  assign ctl.ins   = in_acc && !full;
  assign ctl.shift = out_acc;

  always_comb begin
    drain_nxt = drain_r;
    drop_nxt  = drop_r;
    if (in_acc) begin
      if (full) begin
        drop_nxt = 1'b1;
      end
      if (in_last) begin
        drain_nxt = 1'b1;
      end
    end
    if (out_acc && out_end_of_set) begin
      drain_nxt = 1'b0;
      drop_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
      drop_r  <= drop_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign prev_d[i] = '0;
      assign pgt[i]    = 1'b0;
    end else begin : g_mid
      assign prev_d[i] = cdata[i-1];
      assign pgt[i]    = cgt[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_hi
      assign next_d[i] = '0;
    end else begin : g_nhi
      assign next_d[i] = cdata[i+1];
    end

    iss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ins_val   (in_value),
      .prev_data (prev_d[i]),
      .prev_gt   (pgt[i]),
      .next_data (next_d[i]),
      .data      (cdata[i]),
      .gt        (cgt[i])
    );
  end

  assign out_sorted_value = cdata[0].val;
  assign out_end_of_set   = !cdata[1].vld;
  assign out_overflow     = drop_r;

  // Head cell always holds the beat being offered
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> cdata[0].vld)
    else $error("drain with empty head cell");

  // Chain is empty once the final beat is taken
  a_empty_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_set) |=> !cdata[0].vld && !out_valid)
    else $error("entries left after end of set");

  // No insertion while draining
  a_no_ins_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> !ctl.ins)
    else $error("insert during drain");

endmodule

[dv/insertion_sort_top_tb.sv]
// insertion_sort_top_tb: self-checking testbench for the streaming insertion sorter.
// Depends on iss_pkg and insertion_sort_top; predicts each sorted set and checks every out beat.
`timescale 1ns / 1ps

module insertion_sort_top_tb
  import iss_pkg::*;
;

  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_SLACK  = 20;
  localparam int RANDOM_ITEMS = 100;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     eos;
    logic                     ovf;
  } sorted_beat_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_end_of_set;
  logic                     out_overflow;

  // predictor state: the set held so far, kept ascending, and its dropped flag
  logic signed [DATA_W-1:0] held_set[$];
  logic                     held_dropped;
  sorted_beat_t             sorted_expect_q[$];

  int  err_count;
  int  idle_cycles;
  bit  burst_mode;

  insertion_sort_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflow     (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom;
    if (r < 80) return $signed($urandom_range(0, 8)) - 4;  // small, many duplicates
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2: return {1'b1, {(DATA_W-1){1'b0}}} + 1;
      default: return {1'b0, {(DATA_W-1){1'b1}}} - 1;
    endcase
  endfunction

  // insert one accepted value; on last, queue the whole set in ascending order
  function automatic void predict_sorted_set(logic signed [DATA_W-1:0] v, logic is_last);
    int           pos;
    sorted_beat_t b;
    if (held_set.size() < MAX_ITEMS) begin
      pos = held_set.size();
      while (pos > 0 && held_set[pos-1] > v) pos--;
      held_set.insert(pos, v);
    end else begin
      held_dropped = 1'b1;
    end
    if (is_last) begin
      foreach (held_set[k]) begin
        b.value = held_set[k];
        b.eos   = (k == held_set.size() - 1);
        b.ovf   = held_dropped;
        sorted_expect_q.push_back(b);
      end
      held_set.delete();
      held_dropped = 1'b0;
    end
  endfunction

  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic is_last);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_sorted_set(v, is_last);
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_value(random_value(), i == n - 1);
  endtask

  task automatic test_single_extremes();
    send_value({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
    send_value({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
    send_value('0, 1'b1);
  endtask

  task automatic test_mixed_extremes();
    logic signed [DATA_W-1:0] vals[$];
    vals = {32'sh7fffffff, 32'sh80000000, 0, -1, 1, 1, 32'sh7fffffff, 32'sh80000000,
            32'sh55555555, 32'shaaaaaaaa};
    foreach (vals[i]) send_value(vals[i], i == vals.size() - 1);
  endtask

  task automatic test_descending();
    send_value(5, 1'b0);
    send_value(-5, 1'b1);
    for (int i = 4; i >= 0; i--) send_value(i * 1000 - 2000, i == 0);
  endtask

  // exactly full, full with last dropped, and several dropped values
  task automatic test_store_capacity();
    burst_mode = 1'b0;
    send_random_set(MAX_ITEMS);
    send_random_set(MAX_ITEMS + 1);
    burst_mode = 1'b1;
    send_random_set(MAX_ITEMS + 3);
    burst_mode = 1'b0;
  endtask

  task automatic test_random_sets();
    int sent;
    int n;
    int r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      n = $urandom_range(1, 12);
      else if (r < 90) n = $urandom_range(13, MAX_ITEMS - 1);
      else if (r < 95) n = MAX_ITEMS;
      else             n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      burst_mode = ($urandom_range(0, 3) == 0);
      send_random_set(n);
      sent += n;
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_value     = '0;
    in_last      = 1'b0;
    held_dropped = 1'b0;
    err_count    = 0;
    burst_mode   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_extremes();
    test_mixed_extremes();
    test_descending();
    test_store_capacity();
    test_random_sets();

    @(negedge clk);
    in_valid <= 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (err_count == 0) begin
      $display("insertion_sort_top_tb passed");
    end else begin
      $display("insertion_sort_top_tb failed");
    end
    $finish;
  end

  // receiver stalls: free stretches broken by random stall bursts
  initial begin
    int free_run;
    int stall_len;
    out_stall = 1'b0;
    forever begin
      free_run = $urandom_range(1, 30);
      repeat (free_run) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sorted_beat_t exp_beat;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (sorted_expect_q.size() == 0) begin
        $display("%0t: unexpected out beat, value %0d", $time, out_sorted_value);
        err_count++;
      end else begin
        exp_beat = sorted_expect_q.pop_front();
        if (out_sorted_value !== exp_beat.value) begin
          $display("%0t: sorted_value expected %0d got %0d", $time, exp_beat.value,
                   out_sorted_value);
          err_count++;
        end
        if (out_end_of_set !== exp_beat.eos) begin
          $display("%0t: end_of_set expected %0b got %0b", $time, exp_beat.eos,
                   out_end_of_set);
          err_count++;
        end
        if (out_overflow !== exp_beat.ovf) begin
          $display("%0t: overflow expected %0b got %0b", $time, exp_beat.ovf, out_overflow);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("insertion_sort_top_tb failed");
      $finish;
    end
  end

endmodule
